>>> rtl/tlse_pkg.sv
`timescale 1ns / 1ps

package tlse_pkg;

   // quadrant codes, boundaries on the diagonals; cap marks a figure end
   typedef logic [2:0] quad_type;

   localparam quad_type QUAD_POS_X = 3'd0;
   localparam quad_type QUAD_POS_Y = 3'd1;
   localparam quad_type QUAD_NEG_X = 3'd2;
   localparam quad_type QUAD_NEG_Y = 3'd3;
   localparam quad_type QUAD_CAP   = 3'd4;

   // half a pixel in 16.16 is one shifted up by this much
   localparam int HALF_SHIFT = 15;

   // edge pair slots: segment, join, closing segment, end join, start join
   localparam int EDGE_SLOTS = 5;
   localparam int EDGE_COUNT = 2 * EDGE_SLOTS;
   localparam int EDGE_IDX_W = $clog2(EDGE_COUNT);

   localparam logic [2:0] SLOT_SEG       = 3'd0;
   localparam logic [2:0] SLOT_SEG_JOIN  = 3'd1;
   localparam logic [2:0] SLOT_CLOSE     = 3'd2;
   localparam logic [2:0] SLOT_END_JOIN  = 3'd3;
   localparam logic [2:0] SLOT_START_JOIN = 3'd4;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic               is_first;
      logic               is_last;
      logic               figure_closed;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ex0;
      logic signed [31:0] ey0;
      logic signed [31:0] ex1;
      logic signed [31:0] ey1;
      logic               run_end;
   } rsp_type;

   // offsets in units of half a pixel
   typedef logic signed [2:0] unit_type;

   typedef struct packed {
      unit_type ux;
      unit_type uy;
   } offset_type;

   // everything the edge sequencer needs for one vertex
   typedef struct packed {
      logic signed [31:0]    prior_x;
      logic signed [31:0]    prior_y;
      logic signed [31:0]    cur_x;
      logic signed [31:0]    cur_y;
      logic signed [31:0]    start_x;
      logic signed [31:0]    start_y;
      quad_type              seg_quad;
      quad_type              old_quad;
      quad_type              close_quad;
      quad_type              end_in_quad;
      quad_type              end_out_quad;
      quad_type              wrap_quad;
      quad_type              start_quad;
      logic [EDGE_COUNT-1:0] edge_mask;
   } plan_type;

   function automatic offset_type quad_offset(input quad_type q);
      offset_type o;
      unique case (q)
         QUAD_POS_X: begin o.ux = 3'sd0;  o.uy = -3'sd1; end
         QUAD_POS_Y: begin o.ux = 3'sd1;  o.uy = 3'sd0;  end
         QUAD_NEG_X: begin o.ux = 3'sd0;  o.uy = 3'sd1;  end
         QUAD_NEG_Y: begin o.ux = -3'sd1; o.uy = 3'sd0;  end
         default:    begin o.ux = 3'sd0;  o.uy = 3'sd0;  end
      endcase
      return o;
   endfunction

   function automatic quad_type quad_of(input logic signed [32:0] dx,
                                        input logic signed [32:0] dy);
      logic [32:0] ax;
      logic [32:0] ay;
      quad_type    q;
      ax = dx[32] ? 33'(~dx + 33'sd1) : 33'(dx);
      ay = dy[32] ? 33'(~dy + 33'sd1) : 33'(dy);
      if (ax > ay) begin
         q = dx[32] ? QUAD_NEG_X : QUAD_POS_X;
      end else begin
         q = dy[32] ? QUAD_NEG_Y : QUAD_POS_Y;
      end
      return q;
   endfunction

   // base plus u half pixels, clamped to the signed 32-bit range
   function automatic logic signed [31:0] add_half_sat(input logic signed [31:0] base,
                                                       input unit_type u);
      logic signed [32:0] sum;
      logic signed [31:0] res;
      sum = $signed({base[31], base})
          + $signed({{(33 - 3 - HALF_SHIFT){u[2]}}, u, {HALF_SHIFT{1'b0}}});
      if (sum[32] != sum[31]) begin
         res = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         res = sum[31:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/tlse_plan.sv
`timescale 1ns / 1ps

module tlse_plan (
   input  logic              clock,
   input  logic              reset,
   input  tlse_pkg::req_type job,
   input  logic              advance,
   output tlse_pkg::plan_type plan
);

   logic signed [31:0] start_x_ff, start_x_in;
   logic signed [31:0] start_y_ff, start_y_in;
   logic signed [31:0] prior_x_ff;
   logic signed [31:0] prior_y_ff;
   tlse_pkg::quad_type prior_quad_ff, prior_quad_in;
   tlse_pkg::quad_type start_quad_ff, start_quad_in;
   logic               closed_ff, closed_in;
   logic               seen_ff, seen_in;

   logic signed [32:0] seg_dx, seg_dy, close_dx, close_dy;
   tlse_pkg::quad_type seg_quad, close_quad, wrap_quad;
   tlse_pkg::quad_type pq1, sq1;
   logic signed [31:0] st_x, st_y;
   logic               seg_nz, close_nz, closed1, seen1, tail;
   logic               en_seg, en_join, en_close, en_end, en_wrap;

   always_comb begin
      seg_dx = $signed({job.px[31], job.px}) - $signed({prior_x_ff[31], prior_x_ff});
      seg_dy = $signed({job.py[31], job.py}) - $signed({prior_y_ff[31], prior_y_ff});
      seg_quad = tlse_pkg::quad_of(seg_dx, seg_dy);
      seg_nz = !job.is_first && (job.px != prior_x_ff || job.py != prior_y_ff);

      en_seg = seg_nz;
      // first segment of a closed figure defers its join to the close
      en_join = seg_nz && !(!seen_ff && closed_ff) && (seg_quad != prior_quad_ff);

      st_x    = job.is_first ? job.px : start_x_ff;
      st_y    = job.is_first ? job.py : start_y_ff;
      closed1 = job.is_first ? job.figure_closed : closed_ff;
      seen1   = job.is_first ? 1'b0 : (seen_ff || seg_nz);
      pq1     = job.is_first ? tlse_pkg::QUAD_CAP : (seg_nz ? seg_quad : prior_quad_ff);
      sq1     = job.is_first ? tlse_pkg::QUAD_POS_X :
                ((seg_nz && !seen_ff && closed_ff) ? seg_quad : start_quad_ff);

      close_dx = $signed({st_x[31], st_x}) - $signed({job.px[31], job.px});
      close_dy = $signed({st_y[31], st_y}) - $signed({job.py[31], job.py});
      close_quad = tlse_pkg::quad_of(close_dx, close_dy);
      close_nz = (st_x != job.px) || (st_y != job.py);
      wrap_quad = close_nz ? close_quad : pq1;

      tail     = job.is_last && seen1;
      en_close = tail && closed1 && close_nz;
      en_end   = tail && (closed1 ? (close_nz && close_quad != pq1) : 1'b1);
      en_wrap  = tail && closed1 && (wrap_quad != sq1);

      plan.prior_x      = prior_x_ff;
      plan.prior_y      = prior_y_ff;
      plan.cur_x        = job.px;
      plan.cur_y        = job.py;
      plan.start_x      = st_x;
      plan.start_y      = st_y;
      plan.seg_quad     = seg_quad;
      plan.old_quad     = prior_quad_ff;
      plan.close_quad   = close_quad;
      plan.end_in_quad  = pq1;
      plan.end_out_quad = closed1 ? close_quad : tlse_pkg::QUAD_CAP;
      plan.wrap_quad    = wrap_quad;
      plan.start_quad   = sq1;
      plan.edge_mask    = {en_wrap, en_wrap, en_end, en_end, en_close, en_close,
                           en_join, en_join, en_seg, en_seg};

      if (job.is_last) begin
         start_x_in    = job.px;
         start_y_in    = job.py;
         prior_quad_in = tlse_pkg::QUAD_CAP;
         start_quad_in = tlse_pkg::QUAD_POS_X;
         closed_in     = 1'b0;
         seen_in       = 1'b0;
      end else begin
         start_x_in    = st_x;
         start_y_in    = st_y;
         prior_quad_in = pq1;
         start_quad_in = sq1;
         closed_in     = closed1;
         seen_in       = seen1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         prior_x_ff    <= '0;
         prior_y_ff    <= '0;
         prior_quad_ff <= tlse_pkg::QUAD_CAP;
         start_quad_ff <= tlse_pkg::QUAD_POS_X;
         closed_ff     <= 1'b0;
         seen_ff       <= 1'b0;
      end else if (advance) begin
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         prior_x_ff    <= job.px;
         prior_y_ff    <= job.py;
         prior_quad_ff <= prior_quad_in;
         start_quad_ff <= start_quad_in;
         closed_ff     <= closed_in;
         seen_ff       <= seen_in;
      end
   end

endmodule

>>> rtl/tlse_emit.sv
`timescale 1ns / 1ps

module tlse_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               plan_load,
   input  tlse_pkg::plan_type plan,
   output logic               plan_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlse_pkg::rsp_type  rsp
);

   tlse_pkg::plan_type plan_ff;
   logic [tlse_pkg::EDGE_COUNT-1:0] mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tlse_pkg::rsp_type  rsp_ff, rsp_in;

   logic [tlse_pkg::EDGE_COUNT-1:0] low_bit, rest;
   logic [tlse_pkg::EDGE_IDX_W-1:0] idx;
   logic [2:0]            slot;
   logic                  out_free, emit;
   logic signed [31:0]    p1_x, p1_y, p2_x, p2_y;
   tlse_pkg::quad_type    qi, qo;
   tlse_pkg::offset_type  p, c, a1, a2, d_start, d_end;
   logic signed [31:0]    s_x, s_y, e_x, e_y;

   always_comb begin
      low_bit = mask_ff & (-mask_ff);
      rest    = mask_ff & ~low_bit;
      idx     = '0;
      for (int i = 0; i < tlse_pkg::EDGE_COUNT; i++) begin
         if (low_bit[i]) idx = tlse_pkg::EDGE_IDX_W'(i);
      end
      slot = 3'(idx >> 1);

      out_free   = !rsp_valid_ff || !rsp_stall;
      emit       = (mask_ff != '0) && out_free;
      plan_ready = (mask_ff == '0) || (emit && rest == '0);

      // each slot is a pair of edges between two points with in/out quadrants
      unique case (slot)
         tlse_pkg::SLOT_SEG: begin
            p1_x = plan_ff.prior_x; p1_y = plan_ff.prior_y;
            p2_x = plan_ff.cur_x;   p2_y = plan_ff.cur_y;
            qi = plan_ff.seg_quad;  qo = plan_ff.seg_quad;
         end
         tlse_pkg::SLOT_SEG_JOIN: begin
            p1_x = plan_ff.prior_x; p1_y = plan_ff.prior_y;
            p2_x = plan_ff.prior_x; p2_y = plan_ff.prior_y;
            qi = plan_ff.old_quad;  qo = plan_ff.seg_quad;
         end
         tlse_pkg::SLOT_CLOSE: begin
            p1_x = plan_ff.cur_x;   p1_y = plan_ff.cur_y;
            p2_x = plan_ff.start_x; p2_y = plan_ff.start_y;
            qi = plan_ff.close_quad; qo = plan_ff.close_quad;
         end
         tlse_pkg::SLOT_END_JOIN: begin
            p1_x = plan_ff.cur_x;   p1_y = plan_ff.cur_y;
            p2_x = plan_ff.cur_x;   p2_y = plan_ff.cur_y;
            qi = plan_ff.end_in_quad; qo = plan_ff.end_out_quad;
         end
         tlse_pkg::SLOT_START_JOIN: begin
            p1_x = plan_ff.start_x; p1_y = plan_ff.start_y;
            p2_x = plan_ff.start_x; p2_y = plan_ff.start_y;
            qi = plan_ff.wrap_quad; qo = plan_ff.start_quad;
         end
         default: begin
            p1_x = plan_ff.cur_x;   p1_y = plan_ff.cur_y;
            p2_x = plan_ff.cur_x;   p2_y = plan_ff.cur_y;
            qi = tlse_pkg::QUAD_CAP; qo = tlse_pkg::QUAD_CAP;
         end
      endcase

      p = tlse_pkg::quad_offset(qi);
      c = tlse_pkg::quad_offset(qo);
      // cap corners: turn the other side's offset by a quarter
      if (qi == tlse_pkg::QUAD_CAP) begin
         a1.ux = c.uy;
         a1.uy = -c.ux;
      end else begin
         a1.ux = 3'sd0;
         a1.uy = 3'sd0;
      end
      if (qi != tlse_pkg::QUAD_CAP && qo == tlse_pkg::QUAD_CAP) begin
         a2.ux = -p.uy;
         a2.uy = p.ux;
      end else begin
         a2.ux = 3'sd0;
         a2.uy = 3'sd0;
      end

      if (!idx[0]) begin
         d_start.ux = a1.ux + p.ux; d_start.uy = a1.uy + p.uy;
         d_end.ux   = a2.ux + c.ux; d_end.uy   = a2.uy + c.uy;
         s_x = p1_x; s_y = p1_y; e_x = p2_x; e_y = p2_y;
      end else begin
         d_start.ux = a2.ux - c.ux; d_start.uy = a2.uy - c.uy;
         d_end.ux   = a1.ux - p.ux; d_end.uy   = a1.uy - p.uy;
         s_x = p2_x; s_y = p2_y; e_x = p1_x; e_y = p1_y;
      end

      rsp_in.ex0     = tlse_pkg::add_half_sat(s_x, d_start.ux);
      rsp_in.ey0     = tlse_pkg::add_half_sat(s_y, d_start.uy);
      rsp_in.ex1     = tlse_pkg::add_half_sat(e_x, d_end.ux);
      rsp_in.ey1     = tlse_pkg::add_half_sat(e_y, d_end.uy);
      rsp_in.run_end = (rest == '0);

      if (plan_load) begin
         mask_in = plan.edge_mask;
      end else if (emit) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (plan_load) plan_ff <= plan;
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // a new vertex only lands when the old one is down to its last word or done
   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      plan_load |-> $onehot0(mask_ff))
      else $error("plan loaded over pending edges");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted edge not presented");

   a_mask_holds: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0 && !out_free) |=> $stable(mask_ff))
      else $error("edge list advanced while output blocked");

endmodule

>>> rtl/thin_line_stroke_edges.sv
`timescale 1ns / 1ps

// Thin-line stroke edge generator. Each vertex word is taken into an input
// register; from there combinational logic plans its edges against the stored
// figure state, and an edge sequencer sends them out one word per clock while
// rsp_stall is low. A vertex yields its edges in pairs; the next vertex is taken into
// the sequencer as the last edge of the current one is sent. Vertices that
// yield no edge send nothing. run_end flags the last edge of each vertex.
module thin_line_stroke_edges (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tlse_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tlse_pkg::rsp_type rsp
);

   tlse_pkg::req_type  job_ff;
   logic               job_valid_ff, job_valid_in;
   logic               plan_ready, job_move, req_take;
   tlse_pkg::plan_type plan;

   assign job_move  = job_valid_ff && plan_ready;
   assign req_stall = job_valid_ff && !plan_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         job_valid_in = 1'b1;
      end else if (job_move) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) job_ff <= req;
   end

   tlse_plan u_plan (
      .clock   (clock),
      .reset   (reset),
      .job     (job_ff),
      .advance (job_move),
      .plan    (plan)
   );

   tlse_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .plan_load  (job_move),
      .plan       (plan),
      .plan_ready (plan_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

endmodule
